>>> sv/sha_pkg.sv
// ----------------------------------------------------------------------------
// sha_pkg
// shared constants, round constant table and helper functions for sha-256
// ----------------------------------------------------------------------------
`default_nettype none
package sha_pkg;

    localparam int unsigned BLOCK_BYTES = 64;
    localparam int unsigned ROUNDS      = 64;
    localparam logic [7:0]  PAD_MARK    = 8'h80;
    localparam logic [5:0]  LEN_POS     = 6'd56;

    typedef logic [31:0] word_t;

    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } core_ctl_t;

    function automatic word_t round_k(input logic [5:0] idx);
        word_t k;
        case (idx)
            6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
            6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
            6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
            6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7;  default: k = 32'hc67178f2;
        endcase
        return k;
    endfunction

    function automatic word_t init_h(input logic [2:0] idx);
        word_t h;
        case (idx)
            3'd0: h = 32'h6a09e667;
            3'd1: h = 32'hbb67ae85;
            3'd2: h = 32'h3c6ef372;
            3'd3: h = 32'ha54ff53a;
            3'd4: h = 32'h510e527f;
            3'd5: h = 32'h9b05688c;
            3'd6: h = 32'h1f83d9ab;
            default: h = 32'h5be0cd19;
        endcase
        return h;
    endfunction

    function automatic word_t ror32(input word_t v, input int unsigned n);
        return (v >> n) | (v << (32 - n));
    endfunction

endpackage
`default_nettype wire

>>> sv/sha256_byte_stream_hasher.sv
// ----------------------------------------------------------------------------
// sha256_byte_stream_hasher
// byte-serial sha-256 hasher with padding and word-serial digest output
// ----------------------------------------------------------------------------
// input channel: in_valid/in_ready carry data_byte, byte_present and
// end_of_message. each accepted byte is shifted into the block buffer;
// the 64th byte of a block starts the compression core. in_ready then stays
// low, and no new byte is taken, while the core starts, runs its rounds one
// per cycle and makes the final add, until the state returns to idle.
// an end item adds padding one byte per cycle through the same buffer path
// (up to 72 pad bytes and one or two compressions), then presents eight
// digest words on out_valid/out_ready, word 0 first, last_word on word 7.
// in_ready stays low from acceptance of an end item until word 7 is taken;
// a stalled receiver holds the current word and the block waits.
// reset restores the initial hash and clears the fill and byte counts; the
// block buffer is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none
module sha256_byte_stream_hasher
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  data_byte,
    input  wire logic        byte_present,
    input  wire logic        end_of_message,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [31:0]      digest_word,
    output logic [2:0]       word_index,
    output logic             last_word
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_COMP = 3'd1;
    localparam logic [2:0] ST_PAD  = 3'd2;
    localparam logic [2:0] ST_PCMP = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    logic [2:0]   state_reg, state_next;
    logic [5:0]   fill_reg;
    logic [63:0]  count_reg;
    logic [511:0] blk_reg;
    logic [2:0]   widx_reg;
    logic         marked_reg;
    logic         len_zone_reg;
    logic         len_done_reg;
    logic         start_pend_reg;

    logic [511:0]       block;
    logic               core_start;
    logic               init_hash;
    sha_pkg::word_t     rd_word;
    sha_pkg::core_ctl_t ctl;

    logic        wr_en;
    logic [7:0]  wr_byte;
    logic [63:0] bits;
    logic [2:0]  len_sel;

    assign block   = blk_reg;
    assign bits    = {count_reg[60:0], 3'b000};
    assign len_sel = fill_reg[2:0];

    always_comb
    begin
        wr_en   = 1'b0;
        wr_byte = data_byte;
        if (state_reg == ST_IDLE)
        begin
            wr_en = in_valid && byte_present;
        end
        else if (state_reg == ST_PAD && !start_pend_reg)
        begin
            wr_en = 1'b1;
            if (!marked_reg)
            begin
                wr_byte = sha_pkg::PAD_MARK;
            end
            else if (len_zone_reg && fill_reg >= sha_pkg::LEN_POS)
            begin
                wr_byte = bits[63 - 8*len_sel -: 8];
            end
            else
            begin
                wr_byte = 8'h00;
            end
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign core_start = start_pend_reg;
    assign init_hash = (state_reg == ST_OUT) && out_ready && widx_reg == 3'd7;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (byte_present && fill_reg == 6'd63)
                    begin
                        state_next = end_of_message ? ST_PCMP : ST_COMP;
                    end
                    else if (end_of_message)
                    begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_COMP:
            begin
                if (ctl.done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_PAD:
            begin
                if (!start_pend_reg && fill_reg == 6'd63)
                begin
                    state_next = ST_PCMP;
                end
            end
            ST_PCMP:
            begin
                if (ctl.done)
                begin
                    state_next = (marked_reg && fill_reg == 6'd0 && len_done_reg) ? ST_OUT
                                 : ST_PAD;
                end
            end
            ST_OUT:
            begin
                if (out_ready && widx_reg == 3'd7)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // block buffer as a byte shift register, byte 0 ends up at the top
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            blk_reg <= {blk_reg[503:0], wr_byte};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            fill_reg       <= '0;
            count_reg      <= '0;
            widx_reg       <= '0;
            marked_reg     <= 1'b0;
            len_zone_reg   <= 1'b0;
            len_done_reg   <= 1'b0;
            start_pend_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            start_pend_reg <= 1'b0;
            if (wr_en)
            begin
                fill_reg <= fill_reg + 6'd1;
                if (fill_reg == 6'd63)
                begin
                    start_pend_reg <= 1'b1;
                end
            end
            if (state_reg == ST_IDLE && in_valid)
            begin
                if (byte_present)
                begin
                    count_reg <= count_reg + 64'd1;
                end
                marked_reg   <= 1'b0;
                len_zone_reg <= 1'b0;
                len_done_reg <= 1'b0;
            end
            if (state_reg == ST_PAD && wr_en)
            begin
                marked_reg <= 1'b1;
                // length goes in the block where padding reached below byte 56
                if (fill_reg < sha_pkg::LEN_POS)
                begin
                    len_zone_reg <= 1'b1;
                end
                if (len_zone_reg && fill_reg == 6'd63)
                begin
                    len_done_reg <= 1'b1;
                end
            end
            if (state_reg == ST_OUT && out_ready)
            begin
                widx_reg <= widx_reg + 3'd1;
                if (widx_reg == 3'd7)
                begin
                    count_reg <= '0;
                    fill_reg  <= '0;
                end
            end
        end
    end

    sha_core u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (core_start),
        .block     (block),
        .init_hash (init_hash),
        .rd_index  (widx_reg),
        .rd_word   (rd_word),
        .ctl       (ctl)
    );

    assign out_valid   = (state_reg == ST_OUT);
    assign digest_word = rd_word;
    assign word_index  = widx_reg;
    assign last_word   = (widx_reg == 3'd7);

`ifndef SYNTH
    a_no_in_while_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready) else $error("input open during output");
    a_widx_zero_entry: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> widx_reg == 3'd0) else $error("digest index not at zero");
    a_core_idle_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !ctl.busy) else $error("core busy during output");
`endif

endmodule
`default_nettype wire

>>> sv/sha_core.sv
// ----------------------------------------------------------------------------
// sha_core
// sha-256 compression: one round per cycle over a 16-word schedule window
// ----------------------------------------------------------------------------
`default_nettype none
module sha_core
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    input  wire logic [511:0]              block,
    input  wire logic                      init_hash,
    input  wire logic [2:0]                rd_index,
    output sha_pkg::word_t                 rd_word,
    output sha_pkg::core_ctl_t             ctl
);

    sha_pkg::word_t h_reg [8];
    sha_pkg::word_t v_reg [8];
    sha_pkg::word_t w_reg [16];
    logic [5:0]     round_reg;
    logic           busy_reg;
    logic           done_reg;
    logic           v_pending_reg;

    sha_pkg::word_t s0, s1, w_new, ch, mj, e1, e0, t1, t2, w_cur;

    always_comb
    begin
        w_cur = w_reg[0];
        s0 = sha_pkg::ror32(w_reg[1], 7) ^ sha_pkg::ror32(w_reg[1], 18) ^ (w_reg[1] >> 3);
        s1 = sha_pkg::ror32(w_reg[14], 17) ^ sha_pkg::ror32(w_reg[14], 19)
             ^ (w_reg[14] >> 10);
        w_new = w_reg[0] + s0 + w_reg[9] + s1;
        ch = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
        mj = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
        e1 = sha_pkg::ror32(v_reg[4], 6) ^ sha_pkg::ror32(v_reg[4], 11)
             ^ sha_pkg::ror32(v_reg[4], 25);
        e0 = sha_pkg::ror32(v_reg[0], 2) ^ sha_pkg::ror32(v_reg[0], 13)
             ^ sha_pkg::ror32(v_reg[0], 22);
        t1 = v_reg[7] + e1 + ch + sha_pkg::round_k(round_reg) + w_cur;
        t2 = e0 + mj;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            round_reg <= '0;
            for (int i = 0; i < 8; i++)
            begin
                h_reg[i] <= sha_pkg::init_h(3'(i));
            end
        end
        else
        begin
            done_reg <= 1'b0;
            if (init_hash)
            begin
                for (int i = 0; i < 8; i++)
                begin
                    h_reg[i] <= sha_pkg::init_h(3'(i));
                end
            end
            else if (start && !busy_reg)
            begin
                busy_reg  <= 1'b1;
                round_reg <= '0;
                for (int i = 0; i < 16; i++)
                begin
                    w_reg[i] <= block[511 - 32*i -: 32];
                end
                for (int i = 0; i < 8; i++)
                begin
                    v_reg[i] <= h_reg[i];
                end
            end
            else if (busy_reg)
            begin
                for (int i = 0; i < 15; i++)
                begin
                    w_reg[i] <= w_reg[i+1];
                end
                w_reg[15] <= w_new;
                v_reg[7] <= v_reg[6];
                v_reg[6] <= v_reg[5];
                v_reg[5] <= v_reg[4];
                v_reg[4] <= v_reg[3] + t1;
                v_reg[3] <= v_reg[2];
                v_reg[2] <= v_reg[1];
                v_reg[1] <= v_reg[0];
                v_reg[0] <= t1 + t2;
                round_reg <= round_reg + 6'd1;
                if (round_reg == 6'(sha_pkg::ROUNDS - 1))
                begin
                    busy_reg <= 1'b0;
                end
            end
            else if (v_pending_reg)
            begin
                done_reg <= 1'b1;
                for (int i = 0; i < 8; i++)
                begin
                    h_reg[i] <= h_reg[i] + v_reg[i];
                end
            end
        end
    end

    // final add is made while v_pending_reg is high, which the last round sets
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_pending_reg <= 1'b0;
        end
        else if (busy_reg && round_reg == 6'(sha_pkg::ROUNDS - 1))
        begin
            v_pending_reg <= 1'b1;
        end
        else
        begin
            v_pending_reg <= 1'b0;
        end
    end

    assign rd_word   = h_reg[rd_index];
    assign ctl.start = start;
    assign ctl.busy  = busy_reg || v_pending_reg;
    assign ctl.done  = done_reg;

`ifndef SYNTH
    a_done_after_pending: assert property (@(posedge clk) disable iff (!rst_n)
        v_pending_reg && !init_hash |=> done_reg) else $error("missing final add");
    a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg) else $error("done while busy");
    a_pending_once: assert property (@(posedge clk) disable iff (!rst_n)
        v_pending_reg |=> !v_pending_reg) else $error("pending held");
`endif

endmodule
`default_nettype wire
